// File: src/lpfc_pkg.sv
// lpfc_pkg: shared constants and types for the LRU page-frame cache.
// No dependencies; used by lru_page_frame_cache_top.
package lpfc_pkg;

    // Fixed field widths of the item and configuration ports
    localparam int TABLE_W = 10;
    localparam int PAGE_W  = 32;
    localparam int CFG_W   = 5;
    localparam int TAG_W   = TABLE_W + PAGE_W;

    // Opcodes of an input item
    localparam logic [1:0] OP_ACCESS      = 2'd0;
    localparam logic [1:0] OP_CLOSE_TABLE = 2'd1;
    localparam logic [1:0] OP_FLUSH_ALL   = 2'd2;

    // Reset value of the frame limit register
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef logic [TAG_W-1:0] tag_t;

endpackage

// File: src/lpfc_ram.sv
// lpfc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module lpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read (read returns old data on a collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/lru_page_frame_cache_top.sv
// lru_page_frame_cache_top: fully associative page-frame cache with LRU order.
// Depends on lpfc_pkg and lpfc_ram (tag store and recency links).
//
// Usage:
//   Input channel s_* (valid/ready) carries one item: opcode, table, page, dirty.
//   Opcode access returns one result item; close-table and flush-all return one
//   result item per frame they free (none if nothing matches); opcode 3 returns
//   nothing. m_last marks the final result item of an input item.
//   cfg_wr_en/cfg_wr_data write the frame limit; write it only while idle.
// Timing:
//   One item at a time; s_ready is high only while the sequencer is idle.
//   An access scans the tag RAM one frame per cycle and stops at a hit, then
//   updates the recency list. A miss scans every frame, then fills a free
//   frame while the fill is below the frame limit, else replaces the oldest.
//   A flush walks the recency list oldest first, reading each frame's tag
//   and links and freeing the frame if it matches. Each RAM has a single read port.
// Reset:
//   aresetn (synchronous, active low) empties the cache at once through the
//   valid bits; no clearing pass. The frame limit returns to 16.
// Stall:
//   A result waits in the output register; the sequencer holds while that
//   register is full and not taken, and resumes when m_ready is high.
module lru_page_frame_cache_top #(
    parameter int FRAMES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [lpfc_pkg::CFG_W-1:0]       cfg_wr_data,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_opcode,
    input  logic [lpfc_pkg::TABLE_W-1:0]     s_table_number,
    input  logic [lpfc_pkg::PAGE_W-1:0]      s_page_number,
    input  logic                             s_mark_dirty,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [$clog2(FRAMES)-1:0]        m_frame_index,
    output logic                             m_hit,
    output logic                             m_load_needed,
    output logic                             m_writeback_valid,
    output logic [lpfc_pkg::TABLE_W-1:0]     m_writeback_table,
    output logic [lpfc_pkg::PAGE_W-1:0]      m_writeback_page,
    output logic                             m_last
);

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int CMP_W  = (CNT_W > lpfc_pkg::CFG_W) ? CNT_W : lpfc_pkg::CFG_W;
    localparam int TAG_W  = lpfc_pkg::TAG_W;
    localparam int PAGE_W = lpfc_pkg::PAGE_W;

    localparam logic [LINK_W-1:0] NIL      = LINK_W'(FRAMES);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(FRAMES);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_MISS  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CAP   = 4'd4;
    localparam logic [3:0] S_UNL   = 4'd5;
    localparam logic [3:0] S_INST  = 4'd6;
    localparam logic [3:0] S_LKA   = 4'd7;
    localparam logic [3:0] S_LKB   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_FNEXT = 4'd10;
    localparam logic [3:0] S_FCHK  = 4'd11;

    // What the shared unlink step returns to
    localparam logic [1:0] M_HIT   = 2'd0;
    localparam logic [1:0] M_EVICT = 2'd1;
    localparam logic [1:0] M_FLUSH = 2'd2;

    logic [3:0]                   state_reg, state_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [lpfc_pkg::CFG_W-1:0]   limit_reg, limit_next;
    logic [FRAMES-1:0]            valid_reg, valid_next;
    logic [FRAMES-1:0]            dirty_reg, dirty_next;
    logic [LINK_W-1:0]            newest_reg, newest_next;
    logic [LINK_W-1:0]            oldest_reg, oldest_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;

    // captured input item
    logic [1:0]                   op_reg, op_next;
    logic [lpfc_pkg::TABLE_W-1:0] tbl_reg, tbl_next;
    logic [PAGE_W-1:0]            pg_reg, pg_next;
    logic                         mark_reg, mark_next;

    // scan, walk and link working registers
    logic [CNT_W-1:0]             scan_cnt_reg, scan_cnt_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                         free_found_reg, free_found_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]             f_reg, f_next;
    logic [LINK_W-1:0]            cur_reg, cur_next;
    logic [CNT_W-1:0]             guard_reg, guard_next;
    logic [LINK_W-1:0]            o_reg, o_next;
    logic [LINK_W-1:0]            n_reg, n_next;
    lpfc_pkg::tag_t               tag_reg, tag_next;
    logic                         wbv_reg, wbv_next;

    // pending flush result (held until we know whether it is the last)
    logic                         pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]             pend_frame_reg, pend_frame_next;
    logic                         pend_wbv_reg, pend_wbv_next;
    lpfc_pkg::tag_t               pend_tag_reg, pend_tag_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]             m_frame_reg, m_frame_next;
    logic                         m_hit_reg, m_hit_next;
    logic                         m_load_reg, m_load_next;
    logic                         m_wbv_reg, m_wbv_next;
    logic [lpfc_pkg::TABLE_W-1:0] m_wbt_reg, m_wbt_next;
    logic [PAGE_W-1:0]            m_wbp_reg, m_wbp_next;
    logic                         m_last_reg, m_last_next;

    // RAM ports
    logic                         tag_we;
    logic [IDX_W-1:0]             tag_waddr, tag_raddr;
    lpfc_pkg::tag_t               tag_wdata, tag_rdata;
    logic                         old_we, new_we;
    logic [IDX_W-1:0]             old_waddr, new_waddr, link_raddr;
    logic [LINK_W-1:0]            old_wdata, new_wdata, old_rdata, new_rdata;

    logic                         out_free;
    logic [CMP_W-1:0]             cfg_ext, cap, fill_ext;
    logic [IDX_W-1:0]             evict_idx;
    logic                         flush_match;

    lpfc_ram #(.WIDTH(TAG_W), .DEPTH(FRAMES)) u_tag_ram (
        .aclk(aclk), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
        .rd_addr(tag_raddr), .rd_data(tag_rdata)
    );

    lpfc_ram #(.WIDTH(LINK_W), .DEPTH(FRAMES)) u_older_ram (
        .aclk(aclk), .wr_en(old_we), .wr_addr(old_waddr), .wr_data(old_wdata),
        .rd_addr(link_raddr), .rd_data(old_rdata)
    );

    lpfc_ram #(.WIDTH(LINK_W), .DEPTH(FRAMES)) u_newer_ram (
        .aclk(aclk), .wr_en(new_we), .wr_addr(new_waddr), .wr_data(new_wdata),
        .rd_addr(link_raddr), .rd_data(new_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Clamp the frame limit to 1..FRAMES
    always_comb begin
        cfg_ext  = CMP_W'(limit_reg);
        fill_ext = CMP_W'(fill_reg);
        if (cfg_ext == '0) begin
            cap = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            cap = CMP_W'(FRAMES);
        end else begin
            cap = cfg_ext;
        end
    end

    assign evict_idx   = (oldest_reg < NIL) ? oldest_reg[IDX_W-1:0] : '0;
    assign flush_match = valid_reg[f_reg] &&
                         (op_reg == lpfc_pkg::OP_FLUSH_ALL ||
                          tag_reg[TAG_W-1:PAGE_W] == tbl_reg);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        limit_next      = limit_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        op_next         = op_reg;
        tbl_next        = tbl_reg;
        pg_next         = pg_reg;
        mark_next       = mark_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        f_next          = f_reg;
        cur_next        = cur_reg;
        guard_next      = guard_reg;
        o_next          = o_reg;
        n_next          = n_reg;
        tag_next        = tag_reg;
        wbv_next        = wbv_reg;
        pend_vld_next   = pend_vld_reg;
        pend_frame_next = pend_frame_reg;
        pend_wbv_next   = pend_wbv_reg;
        pend_tag_next   = pend_tag_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_frame_next    = m_frame_reg;
        m_hit_next      = m_hit_reg;
        m_load_next     = m_load_reg;
        m_wbv_next      = m_wbv_reg;
        m_wbt_next      = m_wbt_reg;
        m_wbp_next      = m_wbp_reg;
        m_last_next     = m_last_reg;
        tag_we          = 1'b0;
        tag_waddr       = f_reg;
        tag_wdata       = {tbl_reg, pg_reg};
        tag_raddr       = f_reg;
        old_we          = 1'b0;
        old_waddr       = f_reg;
        old_wdata       = NIL;
        new_we          = 1'b0;
        new_waddr       = f_reg;
        new_wdata       = NIL;
        link_raddr      = f_reg;

        if (cfg_wr_en) begin
            limit_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_opcode;
                    tbl_next  = s_table_number;
                    pg_next   = s_page_number;
                    mark_next = s_mark_dirty;
                    if (s_opcode == lpfc_pkg::OP_ACCESS) begin
                        scan_cnt_next   = '0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end else if (s_opcode == lpfc_pkg::OP_CLOSE_TABLE ||
                                 s_opcode == lpfc_pkg::OP_FLUSH_ALL) begin
                        cur_next      = oldest_reg;
                        guard_next    = '0;
                        pend_vld_next = 1'b0;
                        mode_next     = M_FLUSH;
                        state_next    = S_FNEXT;
                    end
                end
            end

            // one tag read per cycle, compared in the following cycle
            S_SCAN: begin
                if (scan_cnt_reg < CNT_LAST) begin
                    tag_raddr     = scan_cnt_reg[IDX_W-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    if (valid_reg[cmp_idx_reg] && tag_rdata == {tbl_reg, pg_reg}) begin
                        f_next                  = cmp_idx_reg;
                        dirty_next[cmp_idx_reg] = dirty_reg[cmp_idx_reg] | mark_reg;
                        wbv_next                = 1'b0;
                        mode_next               = M_HIT;
                        cmp_vld_next            = 1'b0;
                        state_next              = S_RD;
                    end else if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end else if (scan_cnt_reg == CNT_LAST) begin
                    state_next = S_MISS;
                end
            end

            // pick a free frame or the oldest one
            S_MISS: begin
                mode_next = M_EVICT;
                if (fill_ext < cap && free_found_reg) begin
                    f_next     = free_idx_reg;
                    fill_next  = fill_reg + CNT_W'(1);
                    wbv_next   = 1'b0;
                    state_next = S_INST;
                end else begin
                    f_next = evict_idx;
                    if (valid_reg[evict_idx]) begin
                        wbv_next   = dirty_reg[evict_idx];
                        state_next = S_RD;
                    end else begin
                        fill_next  = fill_reg + CNT_W'(1);
                        wbv_next   = 1'b0;
                        state_next = S_INST;
                    end
                end
            end

            S_RD: begin
                state_next = S_CAP;
            end

            S_CAP: begin
                o_next     = old_rdata;
                n_next     = new_rdata;
                tag_next   = tag_rdata;
                state_next = (mode_reg == M_FLUSH) ? S_FCHK : S_UNL;
            end

            // take f_reg out of the recency list
            S_UNL: begin
                if (n_reg < NIL) begin
                    old_we    = 1'b1;
                    old_waddr = n_reg[IDX_W-1:0];
                    old_wdata = o_reg;
                end else begin
                    newest_next = o_reg;
                end
                if (o_reg < NIL) begin
                    new_we    = 1'b1;
                    new_waddr = o_reg[IDX_W-1:0];
                    new_wdata = n_reg;
                end else begin
                    oldest_next = n_reg;
                end
                case (mode_reg)
                    M_HIT:   state_next = S_LKA;
                    M_EVICT: state_next = S_INST;
                    default: begin
                        cur_next   = n_reg;
                        state_next = S_FNEXT;
                    end
                endcase
            end

            S_INST: begin
                tag_we            = 1'b1;
                valid_next[f_reg] = 1'b1;
                dirty_next[f_reg] = mark_reg;
                state_next        = S_LKA;
            end

            // append f_reg as newest: own links first
            S_LKA: begin
                old_we     = 1'b1;
                old_wdata  = newest_reg;
                new_we     = 1'b1;
                new_wdata  = NIL;
                state_next = S_LKB;
            end

            // then the previous newest points at it
            S_LKB: begin
                if (newest_reg < NIL) begin
                    new_we    = 1'b1;
                    new_waddr = newest_reg[IDX_W-1:0];
                    new_wdata = LINK_W'(f_reg);
                end else begin
                    oldest_next = LINK_W'(f_reg);
                end
                newest_next = LINK_W'(f_reg);
                state_next  = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_frame_next = f_reg;
                    m_hit_next   = (mode_reg == M_HIT);
                    m_load_next  = (mode_reg != M_HIT);
                    m_wbv_next   = wbv_reg;
                    m_wbt_next   = wbv_reg ? tag_reg[TAG_W-1:PAGE_W] : '0;
                    m_wbp_next   = wbv_reg ? tag_reg[PAGE_W-1:0] : '0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // walk step: visit the next frame or finish
            S_FNEXT: begin
                if (cur_reg < NIL && guard_reg < CNT_LAST) begin
                    f_next     = cur_reg[IDX_W-1:0];
                    guard_next = guard_reg + CNT_W'(1);
                    state_next = S_RD;
                end else if (!pend_vld_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = pend_frame_reg;
                    m_hit_next    = 1'b0;
                    m_load_next   = 1'b0;
                    m_wbv_next    = pend_wbv_reg;
                    m_wbt_next    = pend_wbv_reg ? pend_tag_reg[TAG_W-1:PAGE_W] : '0;
                    m_wbp_next    = pend_wbv_reg ? pend_tag_reg[PAGE_W-1:0] : '0;
                    m_last_next   = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            // free a matching frame; the previous one goes out, not last
            S_FCHK: begin
                if (!flush_match) begin
                    cur_next   = n_reg;
                    state_next = S_FNEXT;
                end else if (!pend_vld_reg || out_free) begin
                    if (pend_vld_reg) begin
                        m_valid_next = 1'b1;
                        m_frame_next = pend_frame_reg;
                        m_hit_next   = 1'b0;
                        m_load_next  = 1'b0;
                        m_wbv_next   = pend_wbv_reg;
                        m_wbt_next   = pend_wbv_reg ? pend_tag_reg[TAG_W-1:PAGE_W] : '0;
                        m_wbp_next   = pend_wbv_reg ? pend_tag_reg[PAGE_W-1:0] : '0;
                        m_last_next  = 1'b0;
                    end
                    pend_vld_next     = 1'b1;
                    pend_frame_next   = f_reg;
                    pend_wbv_next     = dirty_reg[f_reg];
                    pend_tag_next     = tag_reg;
                    valid_next[f_reg] = 1'b0;
                    dirty_next[f_reg] = 1'b0;
                    if (fill_reg != '0) begin
                        fill_next = fill_reg - CNT_W'(1);
                    end
                    state_next = S_UNL;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            limit_reg    <= lpfc_pkg::CFG_RESET;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            newest_reg   <= NIL;
            oldest_reg   <= NIL;
            fill_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            newest_reg   <= newest_next;
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        op_reg         <= op_next;
        tbl_reg        <= tbl_next;
        pg_reg         <= pg_next;
        mark_reg       <= mark_next;
        scan_cnt_reg   <= scan_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        f_reg          <= f_next;
        cur_reg        <= cur_next;
        guard_reg      <= guard_next;
        o_reg          <= o_next;
        n_reg          <= n_next;
        tag_reg        <= tag_next;
        wbv_reg        <= wbv_next;
        pend_frame_reg <= pend_frame_next;
        pend_wbv_reg   <= pend_wbv_next;
        pend_tag_reg   <= pend_tag_next;
        m_frame_reg    <= m_frame_next;
        m_hit_reg      <= m_hit_next;
        m_load_reg     <= m_load_next;
        m_wbv_reg      <= m_wbv_next;
        m_wbt_reg      <= m_wbt_next;
        m_wbp_reg      <= m_wbp_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_frame_index     = m_frame_reg;
    assign m_hit             = m_hit_reg;
    assign m_load_needed     = m_load_reg;
    assign m_writeback_valid = m_wbv_reg;
    assign m_writeback_table = m_wbt_reg;
    assign m_writeback_page  = m_wbp_reg;
    assign m_last            = m_last_reg;

`ifndef SYNTH
    // fill count tracks the number of valid frames between items
    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(fill_reg)))
        else $error("fill count differs from valid frame count");

    // list ends are empty together
    a_list_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (newest_reg == NIL) == (oldest_reg == NIL))
        else $error("recency list ends disagree");

    // empty list when idle means no valid frame
    a_list_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ((oldest_reg == NIL) == (valid_reg == '0)))
        else $error("recency list and valid bits disagree");

    // no flush result left behind once idle
    a_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_vld_reg)
        else $error("pending flush item lost");
`endif

endmodule
